[rtl/assert_macros.svh]
// assertion helpers used by json_string_unescape
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk, rstn, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

[rtl/jsu_pkg.sv]
`default_nettype none

package jsu_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_EXP_STRING   = 4'd1;
    localparam logic [3:0] ST_CTRL_CHAR    = 4'd2;
    localparam logic [3:0] ST_BAD_UTF8     = 4'd3;
    localparam logic [3:0] ST_INC_ESCAPE   = 4'd4;
    localparam logic [3:0] ST_BAD_ESCAPE   = 4'd5;
    localparam logic [3:0] ST_INC_UNICODE  = 4'd6;
    localparam logic [3:0] ST_BAD_HEX      = 4'd7;
    localparam logic [3:0] ST_MISSING_LOW  = 4'd8;
    localparam logic [3:0] ST_BAD_LOW      = 4'd9;
    localparam logic [3:0] ST_STRAY_LOW    = 4'd10;
    localparam logic [3:0] ST_NUL          = 4'd11;
    localparam logic [3:0] ST_UNTERMINATED = 4'd12;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       input_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [3:0] status;
    } out_t;

    // one queued action: a code point to encode, or the closing status
    typedef struct packed {
        logic        is_final;
        logic [3:0]  status;
        logic [20:0] cp;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/jsu_front.sv]
`default_nettype none

module jsu_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire jsu_pkg::in_t s_data,
    input  wire logic         q_full,
    output logic              q_push,
    output jsu_pkg::cmd_t     q_cmd
);
    import jsu_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_STR   = 3'd1;
    localparam logic [2:0] PH_UTF8  = 3'd2;
    localparam logic [2:0] PH_ESC   = 3'd3;
    localparam logic [2:0] PH_HEXHI = 3'd4;
    localparam logic [2:0] PH_EXPB  = 3'd5;
    localparam logic [2:0] PH_EXPU  = 3'd6;
    localparam logic [2:0] PH_HEXLO = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  lead_reg, lead_next;
    logic        first_reg, first_next;
    logic [1:0]  need_reg, need_next;
    logic [20:0] partial_reg, partial_next;
    logic [15:0] acc_reg, acc_next;
    logic [2:0]  hcnt_reg, hcnt_next;
    logic        perr_reg, perr_next;
    logic [9:0]  hs_reg, hs_next;

    logic        accept;
    logic [7:0]  b;
    logic        fin;
    logic [3:0]  fin_status;
    logic        emit;
    logic [20:0] emit_cp;
    logic [4:0]  dig;
    logic [20:0] utf_cp;
    logic [15:0] hv;

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] c);
        logic ok;
        if (lead == 8'hE0) begin
            ok = (c >= 8'hA0) && (c <= 8'hBF);
        end else if (lead == 8'hED) begin
            ok = (c >= 8'h80) && (c <= 8'h9F);
        end else if (lead == 8'hF0) begin
            ok = (c >= 8'h90) && (c <= 8'hBF);
        end else if (lead == 8'hF4) begin
            ok = (c >= 8'h80) && (c <= 8'h8F);
        end else begin
            ok = (c >= 8'h80) && (c <= 8'hBF);
        end
        return ok;
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = 5'(c - 8'h37);
        end else begin
            r = 5'd16;
        end
        return r;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.in_byte;
    assign dig     = hex_value(b);
    assign utf_cp  = {partial_reg[14:0], b[5:0]};

    always_comb begin
        phase_next   = phase_reg;
        lead_next    = lead_reg;
        first_next   = first_reg;
        need_next    = need_reg;
        partial_next = partial_reg;
        acc_next     = acc_reg;
        hcnt_next    = hcnt_reg;
        perr_next    = perr_reg;
        hs_next      = hs_reg;
        fin          = 1'b0;
        fin_status   = ST_OK;
        emit         = 1'b0;
        emit_cp      = '0;
        hv           = '0;

        if (accept) begin
            unique case (phase_reg)
                PH_STR: begin
                    if (s_data.input_end) begin
                        fin = 1'b1; fin_status = ST_UNTERMINATED;
                    end else if (b == 8'h22) begin
                        fin = 1'b1; fin_status = ST_OK;
                    end else if (b < 8'h20) begin
                        fin = 1'b1; fin_status = ST_CTRL_CHAR;
                    end else if (b[7]) begin
                        lead_next  = b;
                        first_next = 1'b1;
                        phase_next = PH_UTF8;
                        if (b >= 8'hC2 && b <= 8'hDF) begin
                            partial_next = {16'd0, b[4:0]};
                            need_next    = 2'd1;
                        end else if (b >= 8'hE0 && b <= 8'hEF) begin
                            partial_next = {17'd0, b[3:0]};
                            need_next    = 2'd2;
                        end else if (b >= 8'hF0 && b <= 8'hF4) begin
                            partial_next = {18'd0, b[2:0]};
                            need_next    = 2'd3;
                        end else begin
                            fin = 1'b1; fin_status = ST_BAD_UTF8;
                        end
                    end else if (b == 8'h5C) begin
                        phase_next = PH_ESC;
                    end else begin
                        emit    = 1'b1;
                        emit_cp = {13'd0, b};
                    end
                end
                PH_UTF8: begin
                    if (s_data.input_end || b[7:6] != 2'b10) begin
                        fin = 1'b1; fin_status = ST_BAD_UTF8;
                    end else if (first_reg && !second_ok(lead_reg, b)) begin
                        fin = 1'b1; fin_status = ST_BAD_UTF8;
                    end else begin
                        first_next   = 1'b0;
                        partial_next = utf_cp;
                        need_next    = need_reg - 2'd1;
                        if (need_reg == 2'd1) begin
                            emit       = 1'b1;
                            emit_cp    = utf_cp;
                            phase_next = PH_STR;
                        end
                    end
                end
                PH_ESC: begin
                    phase_next = PH_STR;
                    if (s_data.input_end) begin
                        fin = 1'b1; fin_status = ST_INC_ESCAPE;
                    end else begin
                        unique case (b)
                            8'h22, 8'h5C, 8'h2F: begin emit = 1'b1; emit_cp = {13'd0, b}; end
                            8'h62: begin emit = 1'b1; emit_cp = 21'h08; end
                            8'h66: begin emit = 1'b1; emit_cp = 21'h0C; end
                            8'h6E: begin emit = 1'b1; emit_cp = 21'h0A; end
                            8'h72: begin emit = 1'b1; emit_cp = 21'h0D; end
                            8'h74: begin emit = 1'b1; emit_cp = 21'h09; end
                            8'h75: begin
                                phase_next = PH_HEXHI;
                                acc_next   = '0;
                                hcnt_next  = '0;
                                perr_next  = 1'b0;
                            end
                            default: begin
                                fin = 1'b1; fin_status = ST_BAD_ESCAPE;
                            end
                        endcase
                    end
                end
                PH_HEXHI, PH_HEXLO: begin
                    if (s_data.input_end) begin
                        fin = 1'b1; fin_status = ST_INC_UNICODE;
                    end else begin
                        if (dig[4]) begin
                            perr_next = 1'b1;
                        end else begin
                            acc_next = {acc_reg[11:0], dig[3:0]};
                        end
                        hcnt_next = hcnt_reg + 3'd1;
                        hv        = acc_next;
                        if (hcnt_reg == 3'd3) begin
                            if (perr_next) begin
                                fin = 1'b1; fin_status = ST_BAD_HEX;
                            end else if (phase_reg == PH_HEXHI) begin
                                if (hv[15:10] == 6'b110110) begin
                                    hs_next    = hv[9:0];
                                    phase_next = PH_EXPB;
                                end else if (hv[15:10] == 6'b110111) begin
                                    fin = 1'b1; fin_status = ST_STRAY_LOW;
                                end else if (hv == 16'd0) begin
                                    fin = 1'b1; fin_status = ST_NUL;
                                end else begin
                                    emit       = 1'b1;
                                    emit_cp    = {5'd0, hv};
                                    phase_next = PH_STR;
                                end
                            end else begin
                                if (hv[15:10] != 6'b110111) begin
                                    fin = 1'b1; fin_status = ST_BAD_LOW;
                                end else begin
                                    emit       = 1'b1;
                                    emit_cp    = 21'h10000 + {1'b0, hs_reg, hv[9:0]};
                                    phase_next = PH_STR;
                                end
                            end
                        end
                    end
                end
                PH_EXPB: begin
                    if (s_data.input_end || b != 8'h5C) begin
                        fin = 1'b1; fin_status = ST_MISSING_LOW;
                    end else begin
                        phase_next = PH_EXPU;
                    end
                end
                PH_EXPU: begin
                    if (s_data.input_end || b != 8'h75) begin
                        fin = 1'b1; fin_status = ST_MISSING_LOW;
                    end else begin
                        phase_next = PH_HEXLO;
                        acc_next   = '0;
                        hcnt_next  = '0;
                        perr_next  = 1'b0;
                    end
                end
                PH_IDLE: begin
                    if (s_data.input_end) begin
                        fin = 1'b1; fin_status = ST_EXP_STRING;
                    end else if (b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
                        phase_next = PH_IDLE;
                    end else if (b == 8'h22) begin
                        phase_next = PH_STR;
                    end else begin
                        fin = 1'b1; fin_status = ST_EXP_STRING;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
            // other working registers are reloaded before their next use
            if (fin) begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_comb begin
        q_push       = fin || emit;
        q_cmd        = '0;
        q_cmd.is_final = fin;
        q_cmd.status = fin_status;
        q_cmd.cp     = fin ? 21'd0 : emit_cp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
        lead_reg    <= lead_next;
        first_reg   <= first_next;
        need_reg    <= need_next;
        partial_reg <= partial_next;
        acc_reg     <= acc_next;
        hcnt_reg    <= hcnt_next;
        perr_reg    <= perr_next;
        hs_reg      <= hs_next;
    end

endmodule

`default_nettype wire

[rtl/jsu_queue.sv]
`default_nettype none

module jsu_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire jsu_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output jsu_pkg::cmd_t      head
);
    import jsu_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
        if (do_push) begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/jsu_back.sv]
`default_nettype none

module jsu_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_empty,
    input  wire jsu_pkg::cmd_t q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output jsu_pkg::out_t      m_data
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;
    logic       load;
    logic [1:0] last_idx;
    logic [7:0] enc_byte;
    logic [20:0] cp;

    assign cp = q_head.cp;

    // last byte index of the utf-8 form
    always_comb begin
        if (q_head.is_final || cp <= 21'h7F) begin
            last_idx = 2'd0;
        end else if (cp <= 21'h7FF) begin
            last_idx = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            last_idx = 2'd2;
        end else begin
            last_idx = 2'd3;
        end
    end

    always_comb begin
        enc_byte = 8'h00;
        unique case (last_idx)
            2'd0: enc_byte = cp[7:0];
            2'd1: begin
                unique case (idx_reg)
                    2'd0:    enc_byte = {3'b110, cp[10:6]};
                    default: enc_byte = {2'b10, cp[5:0]};
                endcase
            end
            2'd2: begin
                unique case (idx_reg)
                    2'd0:    enc_byte = {4'b1110, cp[15:12]};
                    2'd1:    enc_byte = {2'b10, cp[11:6]};
                    default: enc_byte = {2'b10, cp[5:0]};
                endcase
            end
            2'd3: begin
                unique case (idx_reg)
                    2'd0: enc_byte = {5'b11110, cp[20:18]};
                    2'd1: enc_byte = {2'b10, cp[17:12]};
                    2'd2: enc_byte = {2'b10, cp[11:6]};
                    2'd3: enc_byte = {2'b10, cp[5:0]};
                endcase
            end
        endcase
    end

    assign load  = !q_empty && (!m_valid_reg || m_ready);
    assign q_pop = load && (idx_reg == last_idx);

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            idx_next     = q_pop ? 2'd0 : idx_reg + 2'd1;
            if (q_head.is_final) begin
                m_data_next.out_byte   = 8'h00;
                m_data_next.byte_valid = 1'b0;
                m_data_next.last       = 1'b1;
                m_data_next.status     = q_head.status;
            end else begin
                m_data_next.out_byte   = enc_byte;
                m_data_next.byte_valid = 1'b1;
                m_data_next.last       = 1'b0;
                m_data_next.status     = ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/json_string_unescape.sv]
// path: a result passes from the input beat through the action queue and the output
//   register to m_, later while the queue still holds earlier work
// throughput: one input byte per cycle while the 4-entry action queue has room;
//   the encoder sends one output beat per cycle while m_ready is high, so a code point
//   of n utf-8 bytes holds the back end for n beats and the queue absorbs the burst
// reset: aresetn synchronous active low; clears parser phase, queue and output valid
`default_nettype none

module json_string_unescape (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire jsu_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output jsu_pkg::out_t     m_data
);
    import jsu_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_cmd, q_head;

    jsu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    jsu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    jsu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`include "assert_macros.svh"

    `ASSERT_SAME(a_final_form, aclk, aresetn, m_valid && m_data.last,
        !m_data.byte_valid && m_data.out_byte == 8'h00, "final beat carries a data byte")
    `ASSERT_SAME(a_data_form, aclk, aresetn, m_valid && !m_data.last,
        m_data.byte_valid && m_data.status == ST_OK, "data beat carries a status")
    `ASSERT_NEXT(a_no_invent, aclk, aresetn, q_empty && !q_push && !m_valid,
        !m_valid, "output beat without queued work")

endmodule

`default_nettype wire
